>>> design/ihc_pkg.sv
// package: shared types and constants of the ipv4 rx header check
`default_nettype none
package ihc_pkg;

  localparam int unsigned POS_W   = 5;
  localparam int unsigned ACC_W   = 20;
  localparam int unsigned CFG_IDX_W = 2;

  localparam logic [15:0]      HDR_BYTES     = 16'd20;
  localparam logic [POS_W-1:0] POS_TLEN_HI   = 5'd2;
  localparam logic [POS_W-1:0] POS_TLEN_LO   = 5'd3;
  localparam logic [POS_W-1:0] POS_PROTO     = 5'd9;
  localparam logic [POS_W-1:0] POS_SRC_FIRST = 5'd12;
  localparam logic [POS_W-1:0] POS_SRC_LAST  = 5'd15;
  localparam logic [POS_W-1:0] POS_DST_FIRST = 5'd16;
  localparam logic [POS_W-1:0] POS_DST_LAST  = 5'd19;
  localparam logic [POS_W-1:0] POS_LAST      = 5'd19;

  localparam logic [31:0] ALL_ONES_ADDR  = 32'hFFFF_FFFF;
  localparam logic [15:0] GOOD_CHECKSUM  = 16'h0000;

  localparam logic [7:0] PROTO_ICMP = 8'd1;
  localparam logic [7:0] PROTO_TCP  = 8'd6;
  localparam logic [7:0] PROTO_UDP  = 8'd17;

  typedef enum logic [2:0] {
    VERDICT_TCP       = 3'd0,
    VERDICT_UDP       = 3'd1,
    VERDICT_ICMP      = 3'd2,
    VERDICT_UNKNOWN   = 3'd3,
    VERDICT_SHORT     = 3'd4,
    VERDICT_NOT_OURS  = 3'd5,
    VERDICT_BAD_CSUM  = 3'd6
  } verdict_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_OWN_ADDR     = 2'd0,
    CFG_SUBNET_BCAST = 2'd1
  } cfg_reg_e;

  typedef struct packed {
    logic [31:0] own_address;
    logic [31:0] subnet_broadcast;
  } cfg_t;

  typedef struct packed {
    verdict_e    verdict;
    logic [7:0]  protocol_number;
    logic [31:0] source_address;
    logic [31:0] dest_address;
    logic [15:0] payload_length;
  } result_t;

  function automatic verdict_e protocol_class(input logic [7:0] proto);
    verdict_e v;
    v = VERDICT_UNKNOWN;
    if (proto == PROTO_TCP) begin
      v = VERDICT_TCP;
    end else if (proto == PROTO_UDP) begin
      v = VERDICT_UDP;
    end else if (proto == PROTO_ICMP) begin
      v = VERDICT_ICMP;
    end
    return v;
  endfunction

endpackage
`default_nettype wire

>>> design/ihc_in_if.sv
// interface: byte input channel
`default_nettype none
interface ihc_in_if;
  logic        valid;
  logic        ready;
  logic [7:0]  data_byte;
  logic        first_byte;
  logic [15:0] buffer_length;

  modport source (output valid, data_byte, first_byte, buffer_length, input ready);
  modport sink   (input valid, data_byte, first_byte, buffer_length, output ready);
endinterface
`default_nettype wire

>>> design/ihc_out_if.sv
// interface: verdict output channel
`default_nettype none
interface ihc_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  verdict;
  logic [7:0]  protocol_number;
  logic [31:0] source_address;
  logic [31:0] dest_address;
  logic [15:0] payload_length;

  modport source (output valid, verdict, protocol_number, source_address, dest_address,
                  payload_length, input ready);
  modport sink   (input valid, verdict, protocol_number, source_address, dest_address,
                  payload_length, output ready);
endinterface
`default_nettype wire

>>> design/ihc_cfg_if.sv
// interface: configuration write channel
`default_nettype none
interface ihc_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [31:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

>>> design/ihc_cfg_regs.sv
// module: configuration register file
`default_nettype none
module ihc_cfg_regs (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  ihc_cfg_if.sink      cfg_i,
  output ihc_pkg::cfg_t cfg_o
);

  ihc_pkg::cfg_t cfg_q, cfg_d;

  assign cfg_i.ready = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_i.valid) begin
      case (cfg_i.index)
        ihc_pkg::CFG_OWN_ADDR:     cfg_d.own_address      = cfg_i.data;
        ihc_pkg::CFG_SUBNET_BCAST: cfg_d.subnet_broadcast = cfg_i.data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.own_address      <= '0;
      cfg_q.subnet_broadcast <= ihc_pkg::ALL_ONES_ADDR;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule
`default_nettype wire

>>> design/ihc_parse.sv
// module: input register and header parse stage
`default_nettype none
module ihc_parse (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  ihc_in_if.sink             in_i,
  input  wire ihc_pkg::cfg_t cfg_i,
  input  wire logic          out_free_i,
  output logic               res_valid_o,
  output ihc_pkg::result_t   res_o
);

  // input register
  logic        in_valid_q, in_valid_d;
  logic [7:0]  in_byte_q;
  logic        in_first_q;
  logic [15:0] in_blen_q;

  // header state
  logic [ihc_pkg::POS_W-1:0] pos_q, pos_d;
  logic                      active_q, active_d;
  logic [ihc_pkg::ACC_W-1:0] acc_q, acc_d;
  logic [7:0]                pend_q, pend_d;
  logic [15:0]               tlen_q, tlen_d;
  logic [15:0]               blen_q, blen_d;
  logic [7:0]                proto_q, proto_d;
  logic [31:0]               src_q, src_d;
  logic [31:0]               dst_q, dst_d;

  logic                      accept;
  logic                      advance;
  logic                      res_valid;
  logic                      short_buf;
  logic                      act_eff;
  logic [ihc_pkg::POS_W-1:0] pos_eff;
  logic [ihc_pkg::ACC_W-1:0] acc_eff;
  logic [16:0]               fold1;
  logic [15:0]               fold2;
  logic [15:0]               min_len;
  logic                      ours;
  ihc_pkg::result_t          res;

  assign short_buf = in_first_q && (in_blen_q < ihc_pkg::HDR_BYTES);
  assign act_eff   = in_first_q ? !short_buf : active_q;
  assign pos_eff   = in_first_q ? '0 : pos_q;
  assign acc_eff   = in_first_q ? '0 : acc_q;

  assign res_valid = in_valid_q && (short_buf || (act_eff && (pos_eff == ihc_pkg::POS_LAST)));
  assign advance   = in_valid_q && (!res_valid || out_free_i);
  assign in_i.ready = !in_valid_q || advance;
  assign accept    = in_i.valid && in_i.ready;

  always_comb begin
    in_valid_d = in_valid_q;
    if (accept) begin
      in_valid_d = 1'b1;
    end else if (advance) begin
      in_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= in_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      in_byte_q  <= in_i.data_byte;
      in_first_q <= in_i.first_byte;
      in_blen_q  <= in_i.buffer_length;
    end
  end

  // field capture; length and address fields are fully shifted in each header
  always_comb begin
    pos_d    = pos_q;
    active_d = act_eff;
    acc_d    = acc_eff;
    pend_d   = pend_q;
    tlen_d   = tlen_q;
    blen_d   = in_first_q ? in_blen_q : blen_q;
    proto_d  = proto_q;
    src_d    = src_q;
    dst_d    = dst_q;
    if (act_eff) begin
      if (!pos_eff[0]) begin
        pend_d = in_byte_q;
      end else begin
        acc_d = acc_eff + {4'd0, pend_q, in_byte_q};
      end
      case (pos_eff) inside
        ihc_pkg::POS_TLEN_HI, ihc_pkg::POS_TLEN_LO: tlen_d = {tlen_q[7:0], in_byte_q};
        ihc_pkg::POS_PROTO:                         proto_d = in_byte_q;
        [ihc_pkg::POS_SRC_FIRST:ihc_pkg::POS_SRC_LAST]: src_d = {src_q[23:0], in_byte_q};
        [ihc_pkg::POS_DST_FIRST:ihc_pkg::POS_DST_LAST]: dst_d = {dst_q[23:0], in_byte_q};
        default: ;
      endcase
      if (pos_eff == ihc_pkg::POS_LAST) begin
        active_d = 1'b0;
        pos_d    = '0;
      end else begin
        pos_d = pos_eff + 1'b1;
      end
    end else if (in_first_q) begin
      pos_d = '0;
    end
  end

  // verdict at the last header byte, or at the first byte of a short buffer
  assign fold1   = {1'b0, acc_d[15:0]} + {13'd0, acc_d[19:16]};
  assign fold2   = fold1[15:0] + {15'd0, fold1[16]};
  assign min_len = (tlen_d < blen_d) ? tlen_d : blen_d;
  assign ours    = (dst_d == cfg_i.own_address) || (dst_d == ihc_pkg::ALL_ONES_ADDR) ||
                   (dst_d == cfg_i.subnet_broadcast);

  always_comb begin
    res = '0;
    if (short_buf) begin
      res.verdict = ihc_pkg::VERDICT_SHORT;
    end else begin
      if (!ours) begin
        res.verdict = ihc_pkg::VERDICT_NOT_OURS;
      end else if (~fold2 != ihc_pkg::GOOD_CHECKSUM) begin
        res.verdict = ihc_pkg::VERDICT_BAD_CSUM;
      end else begin
        res.verdict = ihc_pkg::protocol_class(proto_d);
      end
      res.protocol_number = proto_d;
      res.source_address  = src_d;
      res.dest_address    = dst_d;
      res.payload_length  = (min_len >= ihc_pkg::HDR_BYTES) ? (min_len - ihc_pkg::HDR_BYTES)
                                                           : 16'd0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q    <= '0;
      active_q <= 1'b0;
      acc_q    <= '0;
    end else if (advance) begin
      pos_q    <= pos_d;
      active_q <= active_d;
      acc_q    <= acc_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      pend_q  <= pend_d;
      tlen_q  <= tlen_d;
      blen_q  <= blen_d;
      proto_q <= proto_d;
      src_q   <= src_d;
      dst_q   <= dst_d;
    end
  end

  assign res_valid_o = res_valid && advance;
  assign res_o       = res;

endmodule
`default_nettype wire

>>> design/ihc_result_reg.sv
// module: verdict output register
`default_nettype none
module ihc_result_reg (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             load_i,
  input  wire ihc_pkg::result_t res_i,
  output logic                  out_free_o,
  ihc_out_if.source             out_o
);

  logic             valid_q, valid_d;
  ihc_pkg::result_t res_q;

  assign out_free_o = !valid_q || out_o.ready;

  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = 1'b1;
    end else if (out_o.ready) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

  assign out_o.valid           = valid_q;
  assign out_o.verdict         = res_q.verdict;
  assign out_o.protocol_number = res_q.protocol_number;
  assign out_o.source_address  = res_q.source_address;
  assign out_o.dest_address    = res_q.dest_address;
  assign out_o.payload_length  = res_q.payload_length;

endmodule
`default_nettype wire

>>> design/ipv4_rx_header_check_core.sv
// top level: ipv4 receive header check core
//
// takes a received ipv4 packet one byte per word on in_i, first_byte marking
// the start of a packet and buffer_length valid with it. the fixed 20-byte
// header is parsed on the fly: the ones-complement sum of its ten words is
// accumulated and total length, protocol, source and destination captured.
// one verdict word per packet leaves on res_o: short (buffer below 20 bytes,
// issued right after the first byte, other fields zero), not ours (dest is
// not the own address, the subnet broadcast or all-ones), bad checksum, or
// the class from the protocol (tcp, udp, icmp, unknown). otherwise the
// verdict follows the 20th header byte. payload_length is min(total length,
// buffer length) minus 20, floored at zero. a first byte inside an unfinished
// header drops it silently; bytes outside a header are ignored. throughput is
// one byte per clock unless a verdict waits on a full output register: each
// byte passes an input register, one parse stage (one 20-bit add, fold and
// address compare) and lands in the output register. the output register
// frees as the verdict is taken, so back-to-back packets keep streaming.
// cfg_i writes own_address (index 0) and subnet_broadcast (index 1); write
// it only while the core is idle
`default_nettype none
module ipv4_rx_header_check_core (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  ihc_cfg_if.sink   cfg_i,
  ihc_in_if.sink    in_i,
  ihc_out_if.source res_o
);

  ihc_pkg::cfg_t    cfg;
  ihc_pkg::result_t res;
  logic             res_valid;
  logic             out_free;

  // address registers
  ihc_cfg_regs u_cfg_regs (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_i),
    .cfg_o  (cfg)
  );

  // byte register, header state and verdict logic
  ihc_parse u_parse (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_i),
    .cfg_i       (cfg),
    .out_free_i  (out_free),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  // verdict holding register toward the consumer
  ihc_result_reg u_result_reg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .load_i     (res_valid),
    .res_i      (res),
    .out_free_o (out_free),
    .out_o      (res_o)
  );

endmodule
`default_nettype wire
